// ===== design/lirs_pkg.sv =====
// lirs_pkg: shared sizes, codes, item structs and mark helpers for the
// lirs cache replacement block. No dependencies.

package lirs_pkg;

	localparam int SLOTS      = 32;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ZW         = (CNT_W > 6) ? CNT_W : 6;

	localparam logic [5:0] LIR_LIMIT_RST   = 6'd14;
	localparam logic [4:0] QUEUE_LIMIT_RST = 5'd2;
	localparam logic [5:0] STACK_LIMIT_RST = 6'd18;

	localparam logic [1:0] CFG_LIR_LIMIT   = 2'd0;
	localparam logic [1:0] CFG_QUEUE_LIMIT = 2'd1;
	localparam logic [1:0] CFG_STACK_LIMIT = 2'd2;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// mark bit positions
	localparam int MB_LIR = 0;
	localparam int MB_RES = 1;
	localparam int MB_STK = 2;
	localparam int MB_QUE = 3;

	typedef logic [3:0] marks_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic             push;
		logic             rm;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] slot;
	} lst_op_t;

	function automatic marks_t orphan(input marks_t m);
		orphan = (!m[MB_STK] && !m[MB_QUE]) ? 4'b0000 : m;
	endfunction

	function automatic marks_t stk_rm_marks(input marks_t m, input logic rel);
		marks_t n;
		n = m;
		n[MB_LIR] = 1'b0;
		n[MB_STK] = 1'b0;
		stk_rm_marks = rel ? orphan(n) : n;
	endfunction

	function automatic marks_t que_rm_marks(input marks_t m, input logic rel);
		marks_t n;
		n = m;
		n[MB_RES] = 1'b0;
		n[MB_QUE] = 1'b0;
		que_rm_marks = rel ? orphan(n) : n;
	endfunction

endpackage

// ===== design/lirs_list.sv =====
// lirs_list: ordered list of slot numbers with push at the tail and removal
// at any position (entries above close up). Depends on lirs_pkg.

module lirs_list (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lirs_pkg::lst_op_t          op,
	input  logic [lirs_pkg::IDX_W-1:0] rd_pos,
	output logic [lirs_pkg::IDX_W-1:0] rd_data,
	output logic [lirs_pkg::CNT_W-1:0] cnt
);

	logic [lirs_pkg::IDX_W-1:0] ord_q [lirs_pkg::SLOTS];
	logic [lirs_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (op.rm) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (op.push) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (op.rm) begin
			for (int i = 0; i < lirs_pkg::SLOTS - 1; i++) begin
				if (lirs_pkg::IDX_W'(i) >= op.pos) begin
					ord_q[i] <= ord_q[i+1];
				end
			end
		end else if (op.push) begin
			ord_q[cnt_q[lirs_pkg::IDX_W-1:0]] <= op.slot;
		end
	end

	assign rd_data = ord_q[rd_pos];
	assign cnt     = cnt_q;

endmodule

// ===== design/lirs_cache_replacement.sv =====
// lirs_cache_replacement: top level, slot table, tag/value memories and the
// sequencer that runs the replacement policy. Depends on lirs_pkg, lirs_list.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one request item: lookup,
//   insert or update, or remove. rsp channel (rsp_valid/rsp_stall/rsp) returns
//   one item per request: found flag and the value on a lookup hit.
//   cfg_we/cfg_index/cfg_data write the three limits; write only while idle.
// Timing:
//   a request first scans all slot tags through one comparator, one slot per
//   cycle behind a registered memory read. The policy work then runs list
//   searches and prunes one list entry per cycle before the result is posted.
//   One request is in flight at a time; req_stall is high until its result
//   is placed in the output register.
// Reset:
//   all slots free, stack and queue empty, limits 14/2/18. No clearing pass.
// Stall:
//   the result waits in the output register; the next request is accepted
//   and worked on meanwhile, and waits to post its result until it is taken.

module lirs_cache_replacement (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  lirs_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output lirs_pkg::rsp_t       rsp,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [5:0]           cfg_data
);

	localparam int IW = lirs_pkg::IDX_W;
	localparam int CW = lirs_pkg::CNT_W;
	localparam int ZW = lirs_pkg::ZW;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_SCAN  = 14'b00000000000010,
		S_DISP  = 14'b00000000000100,
		S_STEP  = 14'b00000000001000,
		S_SSRCH = 14'b00000000010000,
		S_QSRCH = 14'b00000000100000,
		S_QHEAD = 14'b00000001000000,
		S_PRUNE = 14'b00000010000000,
		S_RH    = 14'b00000100000000,
		S_SPUSH = 14'b00001000000000,
		S_QPUSH = 14'b00010000000000,
		S_DBRM  = 14'b00100000000000,
		S_DBQ   = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	typedef enum logic [2:0] {
		FL_P1, FL_P2, FL_P3, FL_P4, FL_I1, FL_I2, FL_I3, FL_RM
	} flow_t;

	state_t state_q, st_d;
	flow_t  flow_q, flow_d;

	logic [2:0]    step_q, step_d;
	logic [CW-1:0] p_q, p_d;
	logic [CW-1:0] sc_q;
	logic [IW-1:0] x_q, x_d, t_q, t_d, s_q, f_q;
	logic          rel_q, rel_d, ls_q, ls_d, exc_q, exc_d, wl_q, wl_d;
	logic          hit_q, fr_q, sf_q, sf_d;
	lirs_pkg::marks_t m0_q, m0_d;
	logic [CW-1:0] lir_q, lir_d;
	logic          found_q, found_d;
	logic [lirs_pkg::VALUE_BITS-1:0] val_q, rdv_q, rdv_d;
	lirs_pkg::req_t req_q;

	logic [5:0] lir_lim_q, stk_lim_q;
	logic [4:0] que_lim_q;

	lirs_pkg::rsp_t rsp_q;
	logic           rsp_vld_q;

	// slot table
	lirs_pkg::marks_t mk_q [lirs_pkg::SLOTS];
	logic [IW-1:0]    mk_ra;
	logic             mk_we;
	lirs_pkg::marks_t mk_wd, mk_rd;

	logic [lirs_pkg::KEY_BITS-1:0]   key_mem [lirs_pkg::SLOTS];
	logic [lirs_pkg::VALUE_BITS-1:0] val_mem [lirs_pkg::SLOTS];
	logic [lirs_pkg::KEY_BITS-1:0]   key_s1;
	logic [lirs_pkg::VALUE_BITS-1:0] val_s1;
	lirs_pkg::marks_t mk_s1;
	logic [IW-1:0]    idx_s1;
	logic             vld_s1;
	logic             kwe, vwe;
	logic [IW-1:0]    vwa;

	// lists
	lirs_pkg::lst_op_t sop, qop;
	logic [IW-1:0] srd_pos, srd, qrd_pos, qrd;
	logic [CW-1:0] scnt, qcnt, scap, qcap;
	logic          sfull, qfull, lfull, accept, out_free;

	lirs_list u_stk (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (sop),
		.rd_pos  (srd_pos),
		.rd_data (srd),
		.cnt     (scnt)
	);

	lirs_list u_que (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (qop),
		.rd_pos  (qrd_pos),
		.rd_data (qrd),
		.cnt     (qcnt)
	);

	assign scap = (ZW'(stk_lim_q) > ZW'(lirs_pkg::SLOTS)) ? CW'(lirs_pkg::SLOTS)
		: CW'(stk_lim_q);
	assign qcap = (ZW'(que_lim_q) > ZW'(lirs_pkg::SLOTS)) ? CW'(lirs_pkg::SLOTS)
		: CW'(que_lim_q);
	assign sfull = scnt >= scap;
	assign qfull = qcnt >= qcap;
	assign lfull = ZW'(lir_q) >= ZW'(lir_lim_q);

	assign req_stall = state_q != S_IDLE;
	assign accept    = req_valid && (state_q == S_IDLE);
	assign out_free  = !rsp_vld_q || !rsp_stall;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	assign mk_rd = mk_q[mk_ra];

	always_comb begin
		lirs_pkg::marks_t m;
		st_d    = state_q;
		flow_d  = flow_q;
		step_d  = step_q;
		p_d     = p_q;
		x_d     = x_q;
		t_d     = t_q;
		rel_d   = rel_q;
		ls_d    = ls_q;
		exc_d   = exc_q;
		wl_d    = wl_q;
		sf_d    = sf_q;
		m0_d    = m0_q;
		lir_d   = lir_q;
		found_d = found_q;
		rdv_d   = rdv_q;
		mk_ra   = x_q;
		mk_we   = 1'b0;
		mk_wd   = mk_rd;
		sop     = '0;
		qop     = '0;
		srd_pos = '0;
		qrd_pos = '0;
		kwe     = 1'b0;
		vwe     = 1'b0;
		vwa     = f_q;
		m       = mk_rd;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					st_d = S_SCAN;
				end
			end
			S_SCAN: begin
				mk_ra = sc_q[IW-1:0];
				if (sc_q == CW'(lirs_pkg::SLOTS)) begin
					st_d = S_DISP;
				end
			end
			S_DISP: begin
				mk_ra   = s_q;
				m       = mk_rd;
				t_d     = s_q;
				step_d  = '0;
				found_d = 1'b0;
				rdv_d   = '0;
				st_d    = S_OUT;
				case (req_q.req_type)
					lirs_pkg::REQ_LOOKUP: begin
						if (hit_q && (m[lirs_pkg::MB_LIR] || m[lirs_pkg::MB_RES])) begin
							found_d = 1'b1;
							rdv_d   = val_q;
							st_d    = S_STEP;
							flow_d  = m[lirs_pkg::MB_LIR] ? FL_P1
								: (m[lirs_pkg::MB_STK] ? FL_P2 : FL_P3);
						end
					end
					lirs_pkg::REQ_INSERT: begin
						if (hit_q) begin
							found_d = 1'b1;
							vwe     = 1'b1;
							vwa     = s_q;
							if (m[lirs_pkg::MB_LIR]) begin
								flow_d = FL_P1;
								st_d   = S_STEP;
							end else if (m[lirs_pkg::MB_RES]) begin
								flow_d = m[lirs_pkg::MB_STK] ? FL_P2 : FL_P3;
								st_d   = S_STEP;
							end else if (m[lirs_pkg::MB_STK]) begin
								flow_d = FL_P4;
								st_d   = S_STEP;
							end
						end else if (fr_q) begin
							kwe    = 1'b1;
							vwe    = 1'b1;
							t_d    = f_q;
							sf_d   = sfull;
							flow_d = !lfull ? FL_I1 : (sfull ? FL_I2 : FL_I3);
							st_d   = S_STEP;
						end
					end
					lirs_pkg::REQ_REMOVE: begin
						if (hit_q) begin
							found_d = 1'b1;
							m0_d    = m;
							flow_d  = FL_RM;
							st_d    = S_STEP;
						end
					end
					default: begin
						st_d = S_OUT;
					end
				endcase
			end
			S_STEP: begin
				mk_ra  = t_q;
				m      = mk_rd;
				step_d = step_q + 3'd1;
				x_d    = t_q;
				p_d    = '0;
				case (flow_q)
					FL_P1: begin
						case (step_q)
							3'd0: begin st_d = S_SSRCH; rel_d = 1'b0; end
							3'd1: st_d = S_PRUNE;
							3'd2: begin st_d = S_SPUSH; ls_d = 1'b1; end
							default: st_d = S_OUT;
						endcase
					end
					FL_P2, FL_P4: begin
						case (step_q)
							3'd0: begin
								rel_d = 1'b0;
								if (flow_q == FL_P2) begin
									st_d = S_QSRCH;
								end else if (qcnt != '0) begin
									st_d = S_QHEAD;
								end
							end
							3'd1: begin st_d = S_DBRM; exc_d = 1'b1; end
							3'd2: begin st_d = S_SSRCH; rel_d = 1'b0; end
							3'd3: st_d = S_PRUNE;
							3'd4: begin st_d = S_SPUSH; ls_d = 1'b1; end
							default: st_d = S_OUT;
						endcase
					end
					FL_P3: begin
						case (step_q)
							3'd0: begin st_d = S_QSRCH; rel_d = 1'b0; end
							3'd1: st_d = S_QPUSH;
							3'd2: begin
								if (m == '0) begin
									st_d = S_OUT;
								end else if (sfull) begin
									st_d = S_RH;
								end
							end
							3'd3: begin st_d = S_SPUSH; ls_d = 1'b0; end
							default: st_d = S_OUT;
						endcase
					end
					FL_I1: begin
						case (step_q)
							3'd0: begin
								if (sf_q) begin
									st_d = S_RH;
								end
							end
							3'd1: begin st_d = S_SPUSH; ls_d = 1'b1; end
							default: st_d = S_OUT;
						endcase
					end
					FL_I2: begin
						case (step_q)
							3'd0: begin
								if (qfull && qcnt != '0) begin
									st_d = S_QHEAD;
								end
							end
							3'd1: begin st_d = S_DBRM; exc_d = 1'b0; end
							3'd2: st_d = S_PRUNE;
							3'd3: begin st_d = S_SPUSH; ls_d = 1'b1; end
							default: st_d = S_OUT;
						endcase
					end
					FL_I3: begin
						case (step_q)
							3'd0: begin
								if (qfull && qcnt != '0) begin
									st_d = S_QHEAD;
								end
							end
							3'd1: begin st_d = S_SPUSH; ls_d = 1'b0; end
							3'd2: st_d = S_QPUSH;
							default: st_d = S_OUT;
						endcase
					end
					default: begin
						case (step_q)
							3'd0: begin
								rel_d = 1'b1;
								if (m0_q[lirs_pkg::MB_STK]) begin
									st_d = S_SSRCH;
								end
							end
							3'd1: begin
								if (m0_q[lirs_pkg::MB_STK]) begin
									st_d = S_PRUNE;
								end
							end
							3'd2: begin
								rel_d = 1'b1;
								if (m0_q[lirs_pkg::MB_QUE]) begin
									st_d = S_QSRCH;
								end
							end
							default: begin
								mk_we = 1'b1;
								mk_wd = '0;
								st_d  = S_OUT;
							end
						endcase
					end
				endcase
			end
			S_SSRCH: begin
				srd_pos = p_q[IW-1:0];
				if (p_q >= scnt) begin
					st_d = S_STEP;
				end else if (srd == x_q) begin
					sop.rm  = 1'b1;
					sop.pos = p_q[IW-1:0];
					if (m[lirs_pkg::MB_LIR] && lir_q != '0) begin
						lir_d = lir_q - 1'b1;
					end
					mk_we = 1'b1;
					mk_wd = lirs_pkg::stk_rm_marks(m, rel_q);
					st_d  = S_STEP;
				end else begin
					p_d = p_q + 1'b1;
				end
			end
			S_QSRCH: begin
				qrd_pos = p_q[IW-1:0];
				if (p_q >= qcnt) begin
					st_d = S_STEP;
				end else if (qrd == x_q) begin
					qop.rm  = 1'b1;
					qop.pos = p_q[IW-1:0];
					mk_we   = 1'b1;
					mk_wd   = lirs_pkg::que_rm_marks(m, rel_q);
					st_d    = S_STEP;
				end else begin
					p_d = p_q + 1'b1;
				end
			end
			S_QHEAD: begin
				mk_ra   = qrd;
				m       = mk_rd;
				qop.rm  = 1'b1;
				mk_we   = 1'b1;
				mk_wd   = lirs_pkg::que_rm_marks(m, 1'b1);
				st_d    = S_STEP;
			end
			S_PRUNE: begin
				mk_ra = srd;
				m     = mk_rd;
				if (scnt == '0 || m[lirs_pkg::MB_LIR]) begin
					st_d = S_STEP;
				end else begin
					sop.rm = 1'b1;
					mk_we  = 1'b1;
					mk_wd  = lirs_pkg::stk_rm_marks(m, 1'b1);
				end
			end
			S_RH: begin
				srd_pos = p_q[IW-1:0];
				mk_ra   = srd;
				m       = mk_rd;
				if (p_q >= scnt) begin
					st_d = S_STEP;
				end else if (!m[lirs_pkg::MB_LIR]) begin
					sop.rm  = 1'b1;
					sop.pos = p_q[IW-1:0];
					mk_we   = 1'b1;
					mk_wd   = lirs_pkg::stk_rm_marks(m, 1'b1);
					st_d    = S_STEP;
				end else begin
					p_d = p_q + 1'b1;
				end
			end
			S_SPUSH: begin
				m = mk_rd;
				if (ls_q) begin
					m[lirs_pkg::MB_LIR] = 1'b1;
				end
				mk_we = 1'b1;
				st_d  = S_STEP;
				if (m[lirs_pkg::MB_STK]) begin
					mk_wd = m;
				end else if (sfull || (m[lirs_pkg::MB_LIR] && lfull)) begin
					m[lirs_pkg::MB_LIR] = 1'b0;
					mk_wd = lirs_pkg::orphan(m);
				end else begin
					sop.push = 1'b1;
					sop.slot = x_q;
					if (m[lirs_pkg::MB_LIR]) begin
						lir_d = lir_q + 1'b1;
					end
					m[lirs_pkg::MB_STK] = 1'b1;
					mk_wd = m;
				end
			end
			S_QPUSH: begin
				st_d = S_STEP;
				if (!m[lirs_pkg::MB_QUE]) begin
					mk_we = 1'b1;
					if (qfull) begin
						mk_wd = lirs_pkg::orphan(m);
					end else begin
						qop.push = 1'b1;
						qop.slot = x_q;
						m[lirs_pkg::MB_RES] = 1'b1;
						m[lirs_pkg::MB_QUE] = 1'b1;
						m[lirs_pkg::MB_LIR] = 1'b0;
						mk_wd = m;
					end
				end
			end
			S_DBRM: begin
				mk_ra = srd;
				m     = mk_rd;
				if (scnt == '0 || (exc_q && srd == t_q)) begin
					st_d = S_STEP;
				end else begin
					wl_d   = m[lirs_pkg::MB_LIR];
					x_d    = srd;
					sop.rm = 1'b1;
					if (m[lirs_pkg::MB_LIR] && lir_q != '0) begin
						lir_d = lir_q - 1'b1;
					end
					mk_we = 1'b1;
					mk_wd = lirs_pkg::stk_rm_marks(m, 1'b0);
					st_d  = S_DBQ;
				end
			end
			S_DBQ: begin
				if (wl_q) begin
					st_d = S_QPUSH;
				end else begin
					mk_we = 1'b1;
					mk_wd = lirs_pkg::orphan(m);
					st_d  = S_STEP;
				end
			end
			S_OUT: begin
				if (out_free) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			flow_q    <= FL_P1;
			step_q    <= '0;
			p_q       <= '0;
			lir_q     <= '0;
			hit_q     <= 1'b0;
			fr_q      <= 1'b0;
			vld_s1    <= 1'b0;
			sc_q      <= '0;
			rsp_vld_q <= 1'b0;
			lir_lim_q <= lirs_pkg::LIR_LIMIT_RST;
			que_lim_q <= lirs_pkg::QUEUE_LIMIT_RST;
			stk_lim_q <= lirs_pkg::STACK_LIMIT_RST;
			for (int i = 0; i < lirs_pkg::SLOTS; i++) begin
				mk_q[i] <= '0;
			end
		end else begin
			state_q <= st_d;
			flow_q  <= flow_d;
			step_q  <= step_d;
			p_q     <= p_d;
			lir_q   <= lir_d;
			if (mk_we) begin
				mk_q[mk_ra] <= mk_wd;
			end
			if (accept) begin
				sc_q   <= '0;
				hit_q  <= 1'b0;
				fr_q   <= 1'b0;
				vld_s1 <= 1'b0;
			end else if (state_q == S_SCAN) begin
				vld_s1 <= sc_q < CW'(lirs_pkg::SLOTS);
				if (sc_q < CW'(lirs_pkg::SLOTS)) begin
					sc_q <= sc_q + 1'b1;
				end
				if (vld_s1 && !hit_q && mk_s1 != '0 && key_s1 == req_q.key) begin
					hit_q <= 1'b1;
				end
				if (vld_s1 && !fr_q && mk_s1 == '0) begin
					fr_q <= 1'b1;
				end
			end
			if (state_q == S_OUT && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					lirs_pkg::CFG_LIR_LIMIT:   lir_lim_q <= cfg_data;
					lirs_pkg::CFG_QUEUE_LIMIT: que_lim_q <= cfg_data[4:0];
					lirs_pkg::CFG_STACK_LIMIT: stk_lim_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// payload and scan capture
	always_ff @(posedge clk) begin
		x_q     <= x_d;
		t_q     <= t_d;
		rel_q   <= rel_d;
		ls_q    <= ls_d;
		exc_q   <= exc_d;
		wl_q    <= wl_d;
		sf_q    <= sf_d;
		m0_q    <= m0_d;
		found_q <= found_d;
		rdv_q   <= rdv_d;
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= sc_q[IW-1:0];
			mk_s1  <= mk_rd;
			if (vld_s1 && !hit_q && mk_s1 != '0 && key_s1 == req_q.key) begin
				s_q   <= idx_s1;
				val_q <= val_s1;
			end
			if (vld_s1 && !fr_q && mk_s1 == '0) begin
				f_q <= idx_s1;
			end
		end
		if (state_q == S_OUT && out_free) begin
			rsp_q.found      <= found_q;
			rsp_q.read_value <= rdv_q;
		end
	end

	// tag and value memories
	always_ff @(posedge clk) begin
		if (kwe) begin
			key_mem[f_q] <= req_q.key;
		end
		if (vwe) begin
			val_mem[vwa] <= req_q.write_value;
		end
		key_s1 <= key_mem[sc_q[IW-1:0]];
		val_s1 <= val_mem[sc_q[IW-1:0]];
	end

endmodule
